/* hdl/stvk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stvk_pkg
// Shared widths, types and helpers of the St Venant-Kirchhoff energy pipeline.
// ----------------------------------------------------------------------------
package stvk_pkg;

	localparam int FW   = 16;  // F entry, Q3.13
	localparam int PW   = 2 * FW;
	localparam int ACW  = PW + 2;
	localparam int EW   = 27;  // strain entry, 2^-20 LSB
	localparam int CW   = 32;  // configuration register width
	localparam int IXW  = 2;   // register index width
	localparam int NU   = 6;   // unique entries of a symmetric 3x3 matrix
	localparam int SW   = 44;  // stress entry, 2^-16 LSB
	localparam int OW   = 32;

	localparam logic [IXW-1:0] REG_SHEAR = IXW'(0);
	localparam logic [IXW-1:0] REG_LAME  = IXW'(1);

	typedef logic signed [FW-1:0] fval_t;
	typedef fval_t fmat_t [9];
	typedef logic signed [EW-1:0] eval_t;
	typedef eval_t evec_t [NU];

	// Unique entry order: 00, 11, 22, 01, 02, 12.
	function automatic int uniq_r(input int u);
		int t [NU];
		t = '{0, 1, 2, 0, 0, 1};
		return t[u];
	endfunction

	function automatic int uniq_c(input int u);
		int t [NU];
		t = '{0, 1, 2, 1, 2, 2};
		return t[u];
	endfunction

	function automatic int sym_idx(input int r, input int c);
		int lo;
		int hi;
		lo = (r < c) ? r : c;
		hi = (r < c) ? c : r;
		if (lo == hi) return lo;
		if (lo == 0) return (hi == 1) ? 3 : 4;
		return 5;
	endfunction

	function automatic logic signed [OW-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[OW-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/stvk_strain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stvk_strain
// Two pipeline stages forming the Green strain E = 0.5 (F^T F - I) in Q.20.
// ----------------------------------------------------------------------------
module stvk_strain (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              vld,
	input  stvk_pkg::fmat_t  f,
	output logic             vld_s2,
	output stvk_pkg::fmat_t  f_s2,
	output stvk_pkg::evec_t  e_s2
);
	import stvk_pkg::*;

	logic                   vld_s1;
	fmat_t                  f_s1;
	logic signed [PW-1:0]   prod_s1 [NU][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: column dot products of F, one product per lane.
	always_ff @(posedge clk) begin
		f_s1 <= f;
		for (int u = 0; u < NU; u++) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[u][k] <= f[uniq_r(u) * 3 + k] * f[uniq_c(u) * 3 + k];
			end
		end
	end

	// Stage 2: sum, remove identity on the diagonal, round 2^-27 to 2^-20.
	always_ff @(posedge clk) begin
		logic signed [ACW-1:0] acc;
		logic signed [ACW-1:0] rnd;
		f_s2 <= f_s1;
		for (int u = 0; u < NU; u++) begin
			acc = ACW'(prod_s1[u][0]) + ACW'(prod_s1[u][1]) + ACW'(prod_s1[u][2]);
			if (uniq_r(u) == uniq_c(u)) acc = acc - (ACW'(1) <<< 26);
			rnd = (acc + ACW'(64)) >>> 7;
			e_s2[u] <= rnd[EW-1:0];
		end
	end

endmodule
`default_nettype wire

/* hdl/stvk_energy_gradient.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stvk_energy_gradient
// St Venant-Kirchhoff energy density and its gradient for one 3x3 F.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction takes place at a rising edge where start is high and
// busy is low. The fields f_r0c0 .. f_r2c2 carry F in signed Q3.13, column by
// column. busy is always low: the block is a fully pipelined datapath and takes
// one transaction in every clock cycle.
// Each transaction gives one result: done is high for exactly one cycle and
// energy_value and g_r0c0 .. g_r2c2 (signed Q16.16, saturated) hold the result
// during that cycle. The receiver cannot stall the block and none is needed.
// start is registered through the seven register stages s1 to s7, each about
// one multiplier or one adder tree deep, and done is the valid bit of the
// last stage. Throughput is one transaction per cycle, since every stage
// advances on every clock and nothing ever stalls.
// The configuration port (cfg_we, cfg_idx, cfg_data) writes shear_modulus at
// index 0 and lame_first at index 1; other indexes are
// ignored. Write it only while no transaction is in flight.
// Asynchronous reset clears all pipeline valid bits and sets both moduli to 1.0.
// ----------------------------------------------------------------------------
module stvk_energy_gradient (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          cfg_we,
	input  wire  [stvk_pkg::IXW-1:0]     cfg_idx,
	input  wire  [stvk_pkg::CW-1:0]      cfg_data,
	input  wire  signed [stvk_pkg::FW-1:0] f_r0c0,
	input  wire  signed [stvk_pkg::FW-1:0] f_r1c0,
	input  wire  signed [stvk_pkg::FW-1:0] f_r2c0,
	input  wire  signed [stvk_pkg::FW-1:0] f_r0c1,
	input  wire  signed [stvk_pkg::FW-1:0] f_r1c1,
	input  wire  signed [stvk_pkg::FW-1:0] f_r2c1,
	input  wire  signed [stvk_pkg::FW-1:0] f_r0c2,
	input  wire  signed [stvk_pkg::FW-1:0] f_r1c2,
	input  wire  signed [stvk_pkg::FW-1:0] f_r2c2,
	output logic                         done,
	output logic signed [stvk_pkg::OW-1:0] energy_value,
	output logic signed [stvk_pkg::OW-1:0] g_r0c0,
	output logic signed [stvk_pkg::OW-1:0] g_r1c0,
	output logic signed [stvk_pkg::OW-1:0] g_r2c0,
	output logic signed [stvk_pkg::OW-1:0] g_r0c1,
	output logic signed [stvk_pkg::OW-1:0] g_r1c1,
	output logic signed [stvk_pkg::OW-1:0] g_r2c1,
	output logic signed [stvk_pkg::OW-1:0] g_r0c2,
	output logic signed [stvk_pkg::OW-1:0] g_r1c2,
	output logic signed [stvk_pkg::OW-1:0] g_r2c2
);
	import stvk_pkg::*;

	logic [CW-1:0] shear_q;
	logic [CW-1:0] lame_q;

	fmat_t f_in;
	logic  vld_s2;
	fmat_t f_s2;
	evec_t e_s2;

	logic                 vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	fmat_t                f_s3, f_s4, f_s5, f_s6;
	logic signed [2*EW-1:0] sq_s3 [NU];
	logic signed [EW+1:0]   tr_s3;
	logic signed [EW+CW:0]  mue_s3 [NU];
	logic signed [55:0]     ssq_s4;
	logic signed [2*EW+3:0] tr2_s4;
	logic signed [EW+CW+2:0] lamtr_s4;
	logic signed [EW+CW:0]  mue_s4 [NU];
	logic signed [31:0]     ssq16_s5;
	logic signed [31:0]     tr216_s5;
	logic signed [SW-1:0]   s_s5 [NU];
	logic signed [63:0]     mussq_s6;
	logic signed [63:0]     lamtr2_s6;
	logic signed [FW+SW-1:0] gp_s6 [9][3];
	logic signed [OW-1:0]   en_s7;
	logic signed [OW-1:0]   g_s7 [9];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shear_q <= CW'(65536);
			lame_q  <= CW'(65536);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SHEAR: shear_q <= cfg_data;
				REG_LAME:  lame_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign f_in = '{f_r0c0, f_r1c0, f_r2c0, f_r0c1, f_r1c1, f_r2c1, f_r0c2, f_r1c2, f_r2c2};

	// Stages 1 and 2: Green strain.
	stvk_strain u_strain (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start & ~busy),
		.f      (f_in),
		.vld_s2 (vld_s2),
		.f_s2   (f_s2),
		.e_s2   (e_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 3: squares of E, the trace, and mu times each strain entry.
	always_ff @(posedge clk) begin
		f_s3  <= f_s2;
		tr_s3 <= (EW+2)'(e_s2[0]) + (EW+2)'(e_s2[1]) + (EW+2)'(e_s2[2]);
		for (int u = 0; u < NU; u++) begin
			sq_s3[u]  <= e_s2[u] * e_s2[u];
			mue_s3[u] <= $signed({1'b0, shear_q}) * e_s2[u];
		end
	end

	// Stage 4: sum of squares (off-diagonal entries count twice), tr^2, lambda*tr.
	always_ff @(posedge clk) begin
		f_s4     <= f_s3;
		ssq_s4   <= 56'(sq_s3[0]) + 56'(sq_s3[1]) + 56'(sq_s3[2])
			+ ((56'(sq_s3[3]) + 56'(sq_s3[4]) + 56'(sq_s3[5])) <<< 1);
		tr2_s4   <= tr_s3 * tr_s3;
		lamtr_s4 <= $signed({1'b0, lame_q}) * tr_s3;
		mue_s4   <= mue_s3;
	end

	// Stage 5: round the energy terms to 2^-16 and form the stress entries.
	always_ff @(posedge clk) begin
		logic signed [63:0] v;
		logic signed [63:0] rs;
		logic signed [63:0] r1;
		logic signed [63:0] r2;
		f_s5 <= f_s4;
		r1 = (64'(ssq_s4) + (64'sd1 <<< 23)) >>> 24;
		r2 = (64'(tr2_s4) + (64'sd1 <<< 23)) >>> 24;
		ssq16_s5 <= r1[31:0];
		tr216_s5 <= r2[31:0];
		for (int u = 0; u < NU; u++) begin
			v = 64'(mue_s4[u]) <<< 1;
			if (uniq_r(u) == uniq_c(u)) v = v + 64'(lamtr_s4);
			rs = (v + (64'sd1 <<< 19)) >>> 20;
			s_s5[u] <= rs[SW-1:0];
		end
	end

	// Stage 6: energy products and the 27 products of F times S.
	always_ff @(posedge clk) begin
		logic signed [65:0] pm;
		logic signed [65:0] pl;
		f_s6 <= f_s5;
		pm = $signed({1'b0, shear_q}) * ssq16_s5;
		pl = $signed({1'b0, lame_q}) * tr216_s5;
		mussq_s6  <= pm[63:0];
		lamtr2_s6 <= pl[63:0];
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					gp_s6[c * 3 + r][k] <= f_s5[k * 3 + r] * s_s5[sym_idx(k, c)];
				end
			end
		end
	end

	// Stage 7: final sums, rounding to Q16.16 and saturation.
	always_ff @(posedge clk) begin
		logic signed [63:0] en;
		logic signed [63:0] acc;
		en = (mussq_s6 <<< 1) + lamtr2_s6;
		en_s7 <= sat32((en + (64'sd1 <<< 16)) >>> 17);
		for (int i = 0; i < 9; i++) begin
			acc = 64'(gp_s6[i][0]) + 64'(gp_s6[i][1]) + 64'(gp_s6[i][2]);
			g_s7[i] <= sat32((acc + (64'sd1 <<< 12)) >>> 13);
		end
	end

	assign done         = vld_s7;
	assign energy_value = en_s7;
	assign g_r0c0 = g_s7[0];
	assign g_r1c0 = g_s7[1];
	assign g_r2c0 = g_s7[2];
	assign g_r0c1 = g_s7[3];
	assign g_r1c1 = g_s7[4];
	assign g_r2c1 = g_s7[5];
	assign g_r0c2 = g_s7[6];
	assign g_r1c2 = g_s7[7];
	assign g_r2c2 = g_s7[8];

	// Every accepted transaction leaves the pipeline as a done strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("result missing seven cycles after start");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result without a matching start");

	// The energy is a sum of nonnegative terms.
	a_energy_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !energy_value[OW-1])
		else $error("negative energy");

endmodule
`default_nettype wire

/* test/tb_stvk_energy_gradient.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stvk_energy_gradient
// Self-checking bench for the St Venant-Kirchhoff energy and gradient block.
// A queue of deformation gradients feeds a clocked driver. A clocked monitor
// predicts every accepted transaction and compares each strobed result, field
// by field, against the oldest prediction. The run steps through several
// modulus settings, and each phase uses its own amount of sender idling.
// ----------------------------------------------------------------------------
module tb_stvk_energy_gradient;

	import stvk_pkg::*;

	// One deformation gradient: entry i is the i-th field, column by column.
	typedef logic [8:0][FW-1:0] fgrad_t;
	// Energy at index 0, then the nine gradient entries in the same order.
	typedef logic [9:0][OW-1:0] egrad_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_we;
	logic [IXW-1:0] cfg_idx;
	logic [CW-1:0] cfg_data;
	fgrad_t drive_f;
	logic done;
	logic signed [OW-1:0] energy_value;
	logic signed [OW-1:0] g_r0c0, g_r1c0, g_r2c0, g_r0c1, g_r1c1, g_r2c1;
	logic signed [OW-1:0] g_r0c2, g_r1c2, g_r2c2;

	fgrad_t pending_f [$];
	egrad_t predicted_q [$];
	int idle_pct;
	int mismatches;
	int quiet_cycles;

	// The bench's own copy of the two moduli, tracked from the write port.
	logic [CW-1:0] mu_shadow;
	logic [CW-1:0] lam_shadow;

	stvk_energy_gradient u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.f_r0c0(drive_f[0]), .f_r1c0(drive_f[1]), .f_r2c0(drive_f[2]),
		.f_r0c1(drive_f[3]), .f_r1c1(drive_f[4]), .f_r2c1(drive_f[5]),
		.f_r0c2(drive_f[6]), .f_r1c2(drive_f[7]), .f_r2c2(drive_f[8]),
		.done(done), .energy_value(energy_value),
		.g_r0c0(g_r0c0), .g_r1c0(g_r1c0), .g_r2c0(g_r2c0),
		.g_r0c1(g_r0c1), .g_r1c1(g_r1c1), .g_r2c1(g_r2c1),
		.g_r0c2(g_r0c2), .g_r1c2(g_r1c2), .g_r2c2(g_r2c2)
	);

	always #5 clk = ~clk;

	// Round half up to a coarser LSB: add half of the new LSB, then floor.
	// The arithmetic shift of a signed value is exactly the floor.
	function automatic longint rnd_down(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [OW-1:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[OW-1:0];
	endfunction

	// Energy density and gradient of one F under the current moduli. Every
	// intermediate fits comfortably in 64 bits, so the sums are exact.
	function automatic egrad_t stvk_predict(input fgrad_t fin);
		longint fm [3][3];
		longint strain [3][3];
		longint stress [3][3];
		longint mu, lam, tr, ssq, en, acc;
		egrad_t res;
		mu = longint'({32'b0, mu_shadow});
		lam = longint'({32'b0, lam_shadow});
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++)
				fm[r][c] = longint'($signed(fin[c * 3 + r]));
		// Green strain: F^T F at 2^-26, halved to 2^-27, rounded to Q.20.
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += fm[k][r] * fm[k][c];
				if (r == c)
					acc -= 64'sd1 <<< 26;
				strain[r][c] = rnd_down(acc, 7);
			end
		tr = 0;
		ssq = 0;
		for (int r = 0; r < 3; r++) begin
			tr += strain[r][r];
			for (int c = 0; c < 3; c++)
				ssq += strain[r][c] * strain[r][c];
		end
		en = 2 * mu * rnd_down(ssq, 24) + lam * rnd_down(tr * tr, 24);
		res[0] = clamp32(rnd_down(en, 17));
		// Second Piola-Kirchhoff stress, then the product F * S.
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				acc = 2 * mu * strain[r][c];
				if (r == c)
					acc += lam * tr;
				stress[r][c] = rnd_down(acc, 20);
			end
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += fm[r][k] * stress[k][c];
				res[1 + c * 3 + r] = clamp32(rnd_down(acc, 13));
			end
		return res;
	endfunction

	// Driver: a new F is offered at each falling edge unless the sender idles.
	// The front of the queue stays on the ports until the monitor sees it taken.
	always @(negedge clk) begin
		if (arst_n && pending_f.size() > 0 && $urandom_range(99) >= idle_pct) begin
			start <= 1'b1;
			drive_f <= pending_f[0];
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: registers writes, predicts accepted transactions, checks results.
	always @(posedge clk) begin
		egrad_t seen;
		egrad_t want;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_we) begin
				if (cfg_idx == REG_SHEAR)
					mu_shadow = cfg_data;
				else if (cfg_idx == REG_LAME)
					lam_shadow = cfg_data;
			end
			if (start && !busy) begin
				predicted_q.push_back(stvk_predict(drive_f));
				void'(pending_f.pop_front());
				moved = 1'b1;
			end
			if (done) begin
				moved = 1'b1;
				seen = {g_r2c2, g_r1c2, g_r0c2, g_r2c1, g_r1c1, g_r0c1,
					g_r2c0, g_r1c0, g_r0c0, energy_value};
				if (predicted_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result at %0t", $realtime);
				end else begin
					want = predicted_q.pop_front();
					for (int i = 0; i < 10; i++)
						if (seen[i] !== want[i]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("field %0d mismatch at %0t: expected %h got %h",
									i, $realtime, want[i], seen[i]);
						end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[stvk_energy_gradient] ERROR");
				$finish;
			end
		end
	end

	task automatic wait_idle();
		while (pending_f.size() > 0 || predicted_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One write per call; the enable drops for a cycle before the next write.
	task automatic write_reg(input logic [IXW-1:0] idx, input logic [CW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_f(input int e0, e1, e2, e3, e4, e5, e6, e7, e8);
		fgrad_t v;
		v = {16'(e8), 16'(e7), 16'(e6), 16'(e5), 16'(e4), 16'(e3),
			16'(e2), 16'(e1), 16'(e0)};
		pending_f.push_back(v);
	endtask

	// Most random F are near the identity, as in a live mesh; the rest use the
	// full 16-bit range so every bit and the saturating corners are reached.
	task automatic push_random(input int count);
		fgrad_t v;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++) begin
				if ($urandom_range(99) < 60)
					v[i] = 16'(((i % 4 == 0) ? 8192 : 0) + int'($urandom_range(4096)) - 2048);
				else
					v[i] = 16'($urandom);
			end
			pending_f.push_back(v);
		end
	endtask

	task automatic run_phase(input logic [CW-1:0] mu, input logic [CW-1:0] lam,
			input int pct, input int count);
		wait_idle();
		write_reg(REG_SHEAR, mu);
		write_reg(REG_LAME, lam);
		idle_pct = pct;
		push_random(count);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		drive_f = '0;
		idle_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		mu_shadow = 32'd65536;
		lam_shadow = 32'd65536;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed cases under the reset moduli: the rest state (identity), zero,
		// the field extremes, reflection, shear, a single stretched axis, a tiny alternating F and a rotation.
		push_f(8192, 0, 0, 0, 8192, 0, 0, 0, 8192);
		push_f(0, 0, 0, 0, 0, 0, 0, 0, 0);
		push_f(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		push_f(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		push_f(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
		push_f(-8192, 0, 0, 0, 8192, 0, 0, 0, 8192);
		push_f(8192, 0, 0, 4096, 8192, 0, 0, 0, 8192);
		push_f(16384, 0, 0, 0, 8192, 0, 0, 0, 8192);
		push_f(1, -1, 1, -1, 1, -1, 1, -1, 1);
		push_f(0, 8192, 0, -8192, 0, 0, 0, 0, 8192);
		push_random(190);

		// Moduli sweep, extremes included; each phase has its own idling.
		run_phase(32'd0, 32'd0, 87, 150);
		run_phase(32'hffffffff, 32'hffffffff, 10, 200);
		run_phase(32'd0, 32'hffffffff, 0, 150);
		run_phase(32'hffffffff, 32'd0, 87, 150);
		run_phase(32'd1, 32'd1, 0, 100);
		run_phase($urandom, $urandom, 10, 150);

		// Writes to unused indexes must leave both moduli alone.
		wait_idle();
		write_reg(IXW'(2), $urandom);
		write_reg(IXW'(3), $urandom);
		idle_pct = 0;
		push_f(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		push_f(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
		push_random(48);

		wait_idle();
		if (mismatches == 0)
			$display("[stvk_energy_gradient] OK");
		else
			$display("[stvk_energy_gradient] ERROR");
		$finish;
	end

endmodule
